// ===== design/assert_macros.svh =====
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define CHECK_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CHECK_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define CHECK_PROP(lbl, clk, rst_n, prop, msg)

`define CHECK_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== design/ctcbp_pkg.sv =====
`default_nettype none

package ctcbp_pkg;

    localparam int ROW_W = 12;
    localparam int COL_W = 12;
    localparam int VAL_W = 32;
    localparam int CNT_W = 17;
    localparam int CFG_W = 13;
    localparam int IDX_W = 1;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;
    localparam int TYPE_W      = 3;

    localparam int MAX_BLOCKS_DEFAULT = 16;
    localparam logic [CNT_W-1:0] MAX_ENTRIES = 17'd65536;
    localparam logic [CFG_W-1:0] MAX_DIM     = 13'd4096;

    localparam logic [CFG_W-1:0] BLOCK_HEIGHT_RESET = 13'd64;
    localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 13'd1024;

    localparam logic [IDX_W-1:0] REG_BLOCK_HEIGHT = 1'b0;
    localparam logic [IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    typedef enum logic [TYPE_W-1:0] {
        REC_NONZERO = 3'd0,
        REC_POINTER = 3'd1,
        REC_FULL    = 3'd2,
        REC_PARTIAL = 3'd3,
        REC_SKIP    = 3'd4
    } rec_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NZ,
        ST_CLOSE_A,
        ST_CLOSE_B
    } state_t;

    typedef struct packed {
        logic capture;
        logic emit;
        logic emit_nz;
        logic run_end;
        logic start_close;
        logic close_final;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic row_change;
        logic fin;
        logic out_free;
        logic ptr_next;
    } status_t;

endpackage

`default_nettype wire

// ===== design/ctcbp_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module ctcbp_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  ctcbp_pkg::status_t  st,
    output ctcbp_pkg::cmd_t     cmd
);
    import ctcbp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_NZ;
                end
            end
            ST_NZ:
            begin
                if (st.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.emit_nz = 1'b1;
                    cmd.run_end = !(st.row_change || st.fin);
                    priority if (st.row_change)
                    begin
                        cmd.start_close = 1'b1;
                        state_next      = ST_CLOSE_A;
                    end
                    else if (st.fin)
                    begin
                        cmd.start_close = 1'b1;
                        cmd.close_final = 1'b1;
                        state_next      = ST_CLOSE_B;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLOSE_A:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.ptr_next)
                    begin
                        cmd.run_end = !st.fin;
                        if (st.fin)
                        begin
                            cmd.start_close = 1'b1;
                            cmd.close_final = 1'b1;
                            state_next      = ST_CLOSE_B;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_CLOSE_B:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.ptr_next)
                    begin
                        cmd.run_end = 1'b1;
                        cmd.finish  = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `CHECK_PROP(a_final_close_only_on_fin, clk, rst_n, (state_reg == ST_CLOSE_B) |-> st.fin, "final close without final entry")
    `CHECK_PROP(a_accept_goes_nz, clk, rst_n, (s_tvalid && s_tready) |=> (state_reg == ST_NZ), "accepted transaction did not start")

endmodule

`default_nettype wire

// ===== design/ctcbp_datapath.sv =====
`default_nettype none

`include "assert_macros.svh"

module ctcbp_datapath #(
    parameter int MAX_BLOCKS_PER_ROW = ctcbp_pkg::MAX_BLOCKS_DEFAULT
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_wen,
    input  wire  [ctcbp_pkg::IDX_W-1:0]           cfg_index,
    input  wire  [ctcbp_pkg::CFG_W-1:0]           cfg_wdata,
    input  wire  [ctcbp_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  wire                                   s_tlast,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [ctcbp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [ctcbp_pkg::TYPE_W-1:0]          m_tuser,
    output logic                                  m_tlast,
    input  ctcbp_pkg::cmd_t                       cmd,
    output ctcbp_pkg::status_t                    st
);
    import ctcbp_pkg::*;

    localparam int BLK_W = $clog2(MAX_BLOCKS_PER_ROW + 1);
    localparam int ACC_W = CFG_W + BLK_W;
    localparam logic [BLK_W-1:0] BLK_MAX = BLK_W'(MAX_BLOCKS_PER_ROW);

    logic [CFG_W-1:0] bh_reg, cc_reg;
    logic [ROW_W-1:0] row_reg, prev_row_reg;
    logic [COL_W-1:0] col_reg;
    logic [VAL_W-1:0] val_reg;
    logic             fin_reg;
    logic [CNT_W-1:0] entries_reg, before_reg, last_ptr_reg, ptr_reg, rem_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [BLK_W-1:0] blk_reg;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [TYPE_W-1:0]      m_tuser_reg;
    logic                   m_tlast_reg;

    logic [CFG_W-1:0] h, cols;
    logic             room;
    rec_type_t        kind;
    logic [CNT_W-1:0] new_ptr, base_ptr, cnt_field;
    logic [ACC_W:0]   acc_sum;

    always_comb
    begin
        h        = (bh_reg == '0) ? CFG_W'(1) : bh_reg;
        cols     = (cc_reg > MAX_DIM) ? MAX_DIM : cc_reg;
        room     = blk_reg < BLK_MAX;
        acc_sum  = {1'b0, acc_reg} + (ACC_W+1)'(h);
        priority if (room && (rem_reg >= CNT_W'(h)))
        begin
            kind = REC_FULL;
        end
        else if (room && (rem_reg != '0))
        begin
            kind = REC_PARTIAL;
        end
        else if (room && (acc_sum <= (ACC_W+1)'(cols)))
        begin
            kind = REC_SKIP;
        end
        else
        begin
            kind = REC_POINTER;
        end
        new_ptr  = cmd.close_final ? entries_reg : before_reg;
        base_ptr = (cmd.emit && !cmd.emit_nz) ? ptr_reg : last_ptr_reg;
        unique case (kind)
            REC_POINTER: cnt_field = ptr_reg;
            REC_PARTIAL: cnt_field = CNT_W'(h - rem_reg[CFG_W-1:0]);
            default:     cnt_field = '0;
        endcase
        st.row_change = row_reg != prev_row_reg;
        st.fin        = fin_reg;
        st.out_free   = !m_tvalid_reg || m_tready;
        st.ptr_next   = kind == REC_POINTER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bh_reg       <= BLOCK_HEIGHT_RESET;
            cc_reg       <= COLUMN_COUNT_RESET;
            prev_row_reg <= '0;
            entries_reg  <= '0;
            before_reg   <= '0;
            last_ptr_reg <= '0;
            ptr_reg      <= '0;
            rem_reg      <= '0;
            acc_reg      <= '0;
            blk_reg      <= '0;
            row_reg      <= '0;
            fin_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    REG_BLOCK_HEIGHT: bh_reg <= cfg_wdata;
                    REG_COLUMN_COUNT: cc_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.capture)
            begin
                row_reg    <= s_tdata[ROW_W-1:0];
                fin_reg    <= s_tlast;
                before_reg <= entries_reg;
                if (entries_reg < MAX_ENTRIES)
                begin
                    entries_reg <= entries_reg + 1'b1;
                end
            end
            if (cmd.emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cmd.emit && !cmd.emit_nz)
            begin
                unique case (kind)
                    REC_FULL:
                    begin
                        rem_reg <= rem_reg - CNT_W'(h);
                        acc_reg <= acc_sum[ACC_W-1:0];
                        blk_reg <= blk_reg + 1'b1;
                    end
                    REC_PARTIAL:
                    begin
                        rem_reg <= '0;
                        acc_reg <= acc_sum[ACC_W-1:0];
                        blk_reg <= blk_reg + 1'b1;
                    end
                    REC_SKIP:
                    begin
                        acc_reg <= acc_sum[ACC_W-1:0];
                        blk_reg <= blk_reg + 1'b1;
                    end
                    default:
                    begin
                        last_ptr_reg <= ptr_reg;
                    end
                endcase
            end
            if (cmd.start_close)
            begin
                ptr_reg <= new_ptr;
                rem_reg <= new_ptr - base_ptr;
                acc_reg <= '0;
                blk_reg <= '0;
            end
            if (cmd.finish)
            begin
                if (fin_reg)
                begin
                    prev_row_reg <= '0;
                    entries_reg  <= '0;
                    last_ptr_reg <= '0;
                end
                else
                begin
                    prev_row_reg <= row_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg <= s_tdata[ROW_W +: COL_W];
            val_reg <= s_tdata[ROW_W+COL_W +: VAL_W];
        end
        if (cmd.emit)
        begin
            m_tlast_reg <= cmd.run_end;
            if (cmd.emit_nz)
            begin
                m_tuser_reg <= REC_NONZERO;
                m_tdata_reg <= {3'b000, CNT_W'(0), val_reg, col_reg};
            end
            else
            begin
                m_tuser_reg <= kind;
                m_tdata_reg <= {3'b000, cnt_field, VAL_W'(0), COL_W'(0)};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `CHECK_NEVER(a_blk_bound, clk, rst_n, blk_reg > BLK_MAX, "block code count past limit")
    `CHECK_NEVER(a_ptr_order, clk, rst_n, last_ptr_reg > entries_reg, "row pointer ahead of entry count")
    `CHECK_NEVER(a_entries_sat, clk, rst_n, entries_reg > MAX_ENTRIES, "entry count past saturation")

endmodule

`default_nettype wire

// ===== design/coo_to_csr_block_padding_core.sv =====
// a nonzero record is captured at input, then loaded in ST_NZ into the output register once free
// a new input is accepted only in ST_IDLE, after the last input's record and any row close are emitted
// a row close emits up to MAX_BLOCKS_PER_ROW block codes, then a pointer; the final entry may close two rows
// one record per cycle from the sequencer, paced by the single output register
// reset: rst_n asynchronous, clears counters and row state, block_height 64, column_count 1024
`default_nettype none

module coo_to_csr_block_padding_core #(
    parameter int MAX_BLOCKS_PER_ROW = ctcbp_pkg::MAX_BLOCKS_DEFAULT
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_wen,
    input  wire  [ctcbp_pkg::IDX_W-1:0]        cfg_index,
    input  wire  [ctcbp_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // row_number[11:0], column_number[23:12], entry_value[55:24]
    input  wire  [ctcbp_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire                                s_tlast,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // out_column[11:0], out_value[43:12], count_value[60:44], zero fill
    output logic [ctcbp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // record_type[2:0]
    output logic [ctcbp_pkg::TYPE_W-1:0]       m_tuser,
    output logic                               m_tlast
);
    import ctcbp_pkg::*;

    cmd_t    cmd;
    status_t st;

    ctcbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ctcbp_datapath #(
        .MAX_BLOCKS_PER_ROW (MAX_BLOCKS_PER_ROW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

`default_nettype wire
